### src/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// shared widths and codes for the ising metropolis spin update block
// ----------------------------------------------------------------------------
package isg_pkg;

    localparam int SITE_W = 12;   // row-major site index
    localparam int RAND_W = 14;   // random value for acceptance test
    localparam int THR_W  = 14;   // acceptance thresholds, units of 1/10000
    localparam int MAG_W  = 14;   // running magnetization, two's complement
    localparam int CHG_W  = 3;    // magnetization change, -2 / 0 / +2
    localparam int CFG_AW = 1;    // configuration register index
    localparam int CFG_DW = 14;   // configuration write data

    // request kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_THR_FOUR  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_THR_EIGHT = 1'b1;

endpackage

### src/isg_ram.sv
// ----------------------------------------------------------------------------
// isg_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module isg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/isg_site_map.sv
// ----------------------------------------------------------------------------
// isg_site_map
// splits a row-major site index into row and column, plus wrapped neighbours
// ----------------------------------------------------------------------------
module isg_site_map #(
    parameter int SIDE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [isg_pkg::SITE_W-1:0]  i_site,
    output logic [$clog2(SIDE)-1:0]     o_row_now,
    output logic [$clog2(SIDE)-1:0]     o_row,
    output logic [$clog2(SIDE)-1:0]     o_up,
    output logic [$clog2(SIDE)-1:0]     o_down,
    output logic [$clog2(SIDE)-1:0]     o_col,
    output logic [$clog2(SIDE)-1:0]     o_left,
    output logic [$clog2(SIDE)-1:0]     o_right
);

    import isg_pkg::*;

    localparam int RW   = $clog2(SIDE);
    // reciprocal shift, exact quotient for every 12-bit site
    localparam int K    = SITE_W + RW + 1;
    localparam int MULT = ((2 ** K) + SIDE - 1) / SIDE;
    localparam int PW   = SITE_W + K;
    localparam int QW   = SITE_W + RW;

    localparam logic [RW-1:0] LAST = RW'(SIDE - 1);

    logic [SITE_W-1:0] r_site;
    logic [PW-1:0]     r_prod;
    logic [RW-1:0]     q;
    logic [QW-1:0]     q_times_side;
    logic [QW-1:0]     rem_full;
    logic [RW-1:0]     col;

    logic [RW-1:0] r_row, r_up, r_down, r_col, r_left, r_right;

    // stage 1: multiply by reciprocal
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_site <= i_site;
            r_prod <= PW'(i_site) * PW'(MULT);
        end
    end

    // stage 2: remainder and wrap-around neighbours
    always_comb begin
        q            = r_prod[K +: RW];
        q_times_side = QW'(q) * QW'(SIDE);
        rem_full     = QW'(r_site) - q_times_side;
        col          = rem_full[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_row   <= q;
        r_col   <= col;
        r_up    <= (q == '0)     ? LAST : q - 1'b1;
        r_down  <= (q == LAST)   ? '0   : q + 1'b1;
        r_left  <= (col == '0)   ? LAST : col - 1'b1;
        r_right <= (col == LAST) ? '0   : col + 1'b1;
    end

    assign o_row_now = q;
    assign o_row     = r_row;
    assign o_up      = r_up;
    assign o_down    = r_down;
    assign o_col     = r_col;
    assign o_left    = r_left;
    assign o_right   = r_right;

endmodule

### src/ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// metropolis spin update on a square periodic lattice with running magnetization
// ----------------------------------------------------------------------------
// usage
//   request channel: a request is taken at a rising edge with start high and
//   busy low. kind selects a direct spin load or a metropolis update of site;
//   random_value feeds the acceptance test against the two thresholds.
//   result channel: o_done is high for exactly one cycle and carries flipped,
//   spin_after, magnetization_change and magnetization. the receiver cannot
//   stall, so every result must be taken in its cycle.
//   configuration: i_cfg_we writes i_cfg_data into the threshold picked by i_cfg_addr.
//   the user must write only while no request is in flight; the block does not check.
// sequencing
//   the lattice is held one row per ram word, one ram read port. an update
//   reads its own row, the row above and the row below in turn, then writes
//   its row back. busy falls in the cycle in which o_done is high, so the next
//   request can be taken at the edge that ends that cycle. a load is a single
//   row read-modify-write; a site outside the lattice answers in the next cycle.
// reset
//   the ram is swept to all-up after reset, one row per cycle, with busy held
//   high; thresholds reset to zero, magnetization to SIDE*SIDE.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update #(
    parameter int SIDE = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_kind,
    input  logic [isg_pkg::SITE_W-1:0]        i_site,
    input  logic                              i_spin_value,
    input  logic [isg_pkg::RAND_W-1:0]        i_random_value,
    // result channel
    output logic                              o_done,
    output logic                              o_flipped,
    output logic                              o_spin_after,
    output logic signed [isg_pkg::CHG_W-1:0]  o_magnetization_change,
    output logic signed [isg_pkg::MAG_W-1:0]  o_magnetization,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [isg_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [isg_pkg::CFG_DW-1:0]        i_cfg_data
);

    import isg_pkg::*;

    localparam int RW    = $clog2(SIDE);
    localparam int CELLS = SIDE * SIDE;

    localparam logic [RW-1:0]           LAST_ROW  = RW'(SIDE - 1);
    localparam logic [MAG_W-1:0]        MAG_RESET = MAG_W'(CELLS);
    localparam logic signed [CHG_W-1:0] CHG_UP    = 3'sd2;
    localparam logic signed [CHG_W-1:0] CHG_DOWN  = -3'sd2;
    localparam logic signed [CHG_W-1:0] CHG_NONE  = 3'sd0;
    // count of neighbours equal to the centre spin
    localparam logic [2:0] EQ_FOUR_GATE  = 3'd3;   // energy change of 4

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_MAP,
        S_UP,
        S_DN,
        S_WB
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [THR_W-1:0] r_thr_four, r_thr_eight;

    // request capture
    logic              r_kind;
    logic              r_spin_val;
    logic [RAND_W-1:0] r_rand;
    logic [SIDE-1:0]   r_row_bits, n_row_bits;
    logic              r_up_bit, n_up_bit;

    // clearing sweep and running magnetization
    logic [RW-1:0]    r_clr, n_clr;
    logic [MAG_W-1:0] r_mag, n_mag;

    // registered results
    logic                    r_done, n_done;
    logic                    r_flipped, n_flipped;
    logic                    r_spin_after, n_spin_after;
    logic signed [CHG_W-1:0] r_chg, n_chg;

    // site map
    logic [RW-1:0] map_row_now, map_row, map_up, map_down;
    logic [RW-1:0] map_col, map_left, map_right;

    // lattice ram
    logic            ram_we;
    logic [RW-1:0]   ram_waddr, ram_raddr;
    logic [SIDE-1:0] ram_wdata, ram_rdata;

    // finishing step
    logic            take;
    logic            in_range;
    logic            finish;
    logic [SIDE-1:0] cur_row, new_row;
    logic            old_spin, next_spin, accept_flip;
    logic            eq_up, eq_down, eq_left, eq_right;
    logic [2:0]      n_eq;

    assign take     = start && (r_state == S_IDLE);
    assign in_range = 32'(i_site) < CELLS;

    isg_site_map #(
        .SIDE (SIDE)
    ) u_site_map (
        .i_clk     (i_clk),
        .i_load    (take),
        .i_site    (i_site),
        .o_row_now (map_row_now),
        .o_row     (map_row),
        .o_up      (map_up),
        .o_down    (map_down),
        .o_col     (map_col),
        .o_left    (map_left),
        .o_right   (map_right)
    );

    isg_ram #(
        .WIDTH (SIDE),
        .DEPTH (SIDE)
    ) u_lattice (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // acceptance and row rewrite, shared by the load and update endings
    always_comb begin
        // a load ends while its row is on the read port, an update once the row is held
        cur_row  = (r_state == S_UP) ? ram_rdata : r_row_bits;
        old_spin = cur_row[map_col];

        eq_up    = ~(r_up_bit ^ old_spin);
        eq_down  = ~(ram_rdata[map_col] ^ old_spin);
        eq_left  = ~(r_row_bits[map_left] ^ old_spin);
        eq_right = ~(r_row_bits[map_right] ^ old_spin);
        n_eq     = {2'b00, eq_up} + {2'b00, eq_down} + {2'b00, eq_left} + {2'b00, eq_right};

        // energy change 4*n_eq - 8: at most zero flips always
        if (n_eq < EQ_FOUR_GATE) begin
            accept_flip = 1'b1;
        end else if (n_eq == EQ_FOUR_GATE) begin
            accept_flip = r_rand < r_thr_four;
        end else begin
            accept_flip = r_rand < r_thr_eight;
        end

        if (r_kind == KIND_LOAD) begin
            next_spin = r_spin_val;
        end else begin
            next_spin = accept_flip ? ~old_spin : old_spin;
        end

        new_row          = cur_row;
        new_row[map_col] = next_spin;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_mag        = r_mag;
        n_done       = 1'b0;
        n_flipped    = r_flipped;
        n_spin_after = r_spin_after;
        n_chg        = r_chg;
        n_row_bits   = r_row_bits;
        n_up_bit     = r_up_bit;
        finish       = 1'b0;

        ram_we    = 1'b0;
        ram_waddr = map_row;
        ram_wdata = new_row;
        ram_raddr = map_row_now;

        case (r_state)
            S_CLR: begin
                // sweep every row to all-up
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '1;
                if (r_clr == LAST_ROW) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (take) begin
                    if (in_range) begin
                        n_state = S_MAP;
                    end else begin
                        // site outside the lattice: answer at once, nothing changes
                        n_done       = 1'b1;
                        n_flipped    = 1'b0;
                        n_spin_after = 1'b0;
                        n_chg        = CHG_NONE;
                    end
                end
            end
            S_MAP: begin
                ram_raddr = map_row_now;
                n_state   = S_UP;
            end
            S_UP: begin
                n_row_bits = ram_rdata;
                ram_raddr  = map_up;
                if (r_kind == KIND_LOAD) begin
                    finish = 1'b1;
                end else begin
                    n_state = S_DN;
                end
            end
            S_DN: begin
                n_up_bit  = ram_rdata[map_col];
                ram_raddr = map_down;
                n_state   = S_WB;
            end
            S_WB: begin
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            ram_we       = 1'b1;
            n_state      = S_IDLE;
            n_done       = 1'b1;
            n_spin_after = next_spin;
            n_flipped    = next_spin != old_spin;
            if (next_spin != old_spin) begin
                n_chg = next_spin ? CHG_UP : CHG_DOWN;
                n_mag = next_spin ? r_mag + MAG_W'(2) : r_mag - MAG_W'(2);
            end else begin
                n_chg = CHG_NONE;
            end
        end
    end

    // state, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_mag        <= MAG_RESET;
            r_thr_four   <= '0;
            r_thr_eight  <= '0;
            r_done       <= 1'b0;
            r_flipped    <= 1'b0;
            r_spin_after <= 1'b0;
            r_chg        <= CHG_NONE;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_mag        <= n_mag;
            r_done       <= n_done;
            r_flipped    <= n_flipped;
            r_spin_after <= n_spin_after;
            r_chg        <= n_chg;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_THR_FOUR:  r_thr_four  <= i_cfg_data[THR_W-1:0];
                    CFG_THR_EIGHT: r_thr_eight <= i_cfg_data[THR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // request payload and neighbour bits
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind     <= i_kind;
            r_spin_val <= i_spin_value;
            r_rand     <= i_random_value;
        end
        r_row_bits <= n_row_bits;
        r_up_bit   <= n_up_bit;
    end

    assign busy                   = r_state != S_IDLE;
    assign o_done                 = r_done;
    assign o_flipped              = r_flipped;
    assign o_spin_after           = r_spin_after;
    assign o_magnetization_change = r_chg;
    assign o_magnetization        = r_mag;

endmodule

### test/tb_ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// tb_ising_metropolis_spin_update
// self-checking bench: a lattice mirror predicts every result of the spin
// update block; directed corner and threshold cases, then random neighbourhood
// trials and stray requests under three sender idle profiles and changing thresholds
// ----------------------------------------------------------------------------
module tb_ising_metropolis_spin_update;
    timeunit 1ns;
    timeprecision 1ps;

    import isg_pkg::*;

    localparam int LATTICE_SIDE   = 64;
    localparam int CELL_COUNT     = LATTICE_SIDE * LATTICE_SIDE;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no request and no result taken
    localparam int BLOCKS_PER_PHASE = 4;
    localparam int REQUESTS_PER_BLOCK = 103;

    // ------------------------------------------------------------------------
    // lattice mirror: own copy of spins, magnetization and thresholds, plus
    // the queue of outcomes still owed by the block
    // ------------------------------------------------------------------------
    class t_lattice_mirror #(int SIDE = 64);
        typedef struct packed {
            logic                     flipped;
            logic                     spin_after;
            logic signed [CHG_W-1:0]  mag_change;
            logic signed [MAG_W-1:0]  magnetization;
        } t_outcome;

        bit               spin_up [SIDE*SIDE];
        int               total;
        logic [THR_W-1:0] thr_four;
        logic [THR_W-1:0] thr_eight;
        t_outcome         pending_outcomes [$];
        int               mismatches;

        function new();
            foreach (spin_up[i]) spin_up[i] = 1'b1;
            total      = SIDE * SIDE;
            thr_four   = '0;
            thr_eight  = '0;
            mismatches = 0;
        endfunction

        // wrapped neighbour: 0 above, 1 below, 2 left, 3 right
        static function int neighbour_of(int site, int dir);
            int row;
            int col;
            row = site / SIDE;
            col = site % SIDE;
            case (dir)
                0: row = (row == 0) ? SIDE - 1 : row - 1;
                1: row = (row == SIDE - 1) ? 0 : row + 1;
                2: col = (col == 0) ? SIDE - 1 : col - 1;
                default: col = (col == SIDE - 1) ? 0 : col + 1;
            endcase
            return row * SIDE + col;
        endfunction

        function void set_threshold(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_THR_FOUR:  thr_four  = THR_W'(val);
                CFG_THR_EIGHT: thr_eight = THR_W'(val);
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction

        // apply one request to the mirror and queue the outcome it owes
        function void apply_request(logic kind, logic [SITE_W-1:0] site,
                                    logic spin_value, logic [RAND_W-1:0] rnd);
            t_outcome o;
            int       idx;
            int       nsum;
            int       s;
            int       de;
            bit       accept;
            bit       prev;
            bit       nxt;
            o   = '0;
            idx = int'(site);
            if (idx < SIDE * SIDE) begin
                prev = spin_up[idx];
                nxt  = prev;
                if (kind == KIND_LOAD) begin
                    nxt = spin_value;
                end else begin
                    nsum = 0;
                    for (int d = 0; d < 4; d++)
                        nsum += spin_up[neighbour_of(idx, d)] ? 1 : -1;
                    s  = prev ? 1 : -1;
                    de = 2 * nsum * s;
                    if (de <= 0)
                        accept = 1'b1;
                    else if (de == 4)
                        accept = (rnd < thr_four);
                    else
                        accept = (rnd < thr_eight);
                    if (accept)
                        nxt = !prev;
                end
                if (nxt != prev) begin
                    o.flipped    = 1'b1;
                    o.mag_change = CHG_W'(nxt ? 2 : -2);
                    spin_up[idx] = nxt;
                    total       += nxt ? 2 : -2;
                end
                o.spin_after = nxt;
            end
            o.magnetization = MAG_W'(total);
            pending_outcomes.push_back(o);
        endfunction

        function void compare_outcome(logic flipped, logic spin_after,
                                      logic signed [CHG_W-1:0] chg,
                                      logic signed [MAG_W-1:0] mag);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                $error("result with no request waiting: flipped %0d magnetization %0d",
                       flipped, $signed(mag));
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (flipped !== want.flipped) begin
                    $error("flipped: expected %0d, got %0d", want.flipped, flipped);
                    mismatches++;
                end
                if (spin_after !== want.spin_after) begin
                    $error("spin_after: expected %0d, got %0d", want.spin_after, spin_after);
                    mismatches++;
                end
                if (chg !== want.mag_change) begin
                    $error("magnetization_change: expected %0d, got %0d",
                           $signed(want.mag_change), $signed(chg));
                    mismatches++;
                end
                if (mag !== want.magnetization) begin
                    $error("magnetization: expected %0d, got %0d",
                           $signed(want.magnetization), $signed(mag));
                    mismatches++;
                end
            end
        endfunction
    endclass

    typedef t_lattice_mirror #(LATTICE_SIDE) t_mirror;

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every driven input is known from time zero
    // ------------------------------------------------------------------------
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     start          = 1'b0;
    logic                     busy;
    logic                     i_kind         = KIND_LOAD;
    logic [SITE_W-1:0]        i_site         = '0;
    logic                     i_spin_value   = 1'b0;
    logic [RAND_W-1:0]        i_random_value = '0;
    logic                     o_done;
    logic                     o_flipped;
    logic                     o_spin_after;
    logic signed [CHG_W-1:0]  o_magnetization_change;
    logic signed [MAG_W-1:0]  o_magnetization;
    logic                     i_cfg_we       = 1'b0;
    logic [CFG_AW-1:0]        i_cfg_addr     = CFG_THR_FOUR;
    logic [CFG_DW-1:0]        i_cfg_data     = '0;

    t_mirror lattice;
    int      requests_sent   = 0;
    int      sender_idle_pct = 0;   // chance in a hundred of idling before a request
    int      focus_site      = 0;   // stray requests gather around the last trial
    int      idle_cycles     = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ising_metropolis_spin_update #(
        .SIDE (LATTICE_SIDE)
    ) dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .start                  (start),
        .busy                   (busy),
        .i_kind                 (i_kind),
        .i_site                 (i_site),
        .i_spin_value           (i_spin_value),
        .i_random_value         (i_random_value),
        .o_done                 (o_done),
        .o_flipped              (o_flipped),
        .o_spin_after           (o_spin_after),
        .o_magnetization_change (o_magnetization_change),
        .o_magnetization        (o_magnetization),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_addr             (i_cfg_addr),
        .i_cfg_data             (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // result monitor: every strobe is taken in its own cycle
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1)
            lattice.compare_outcome(o_flipped, o_spin_after,
                                    o_magnetization_change, o_magnetization);
    end

    // watchdog: too long without a request or a result taken ends the run
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // helpers for stimulus values
    // ------------------------------------------------------------------------
    // mostly in-range random values, now and then the full 14-bit span
    function automatic int random_draw();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, (1 << RAND_W) - 1));
        return int'($urandom_range(0, 9999));
    endfunction

    // thresholds lean on the extremes: never, always, above range
    function automatic logic [CFG_DW-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return CFG_DW'(0);
            1: return CFG_DW'(10000);
            2: return CFG_DW'((1 << CFG_DW) - 1);
            3: return CFG_DW'(1);
            default: return CFG_DW'($urandom_range(0, 10000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request driver: optional idle gap, then hold the request until busy is
    // low at an edge; start is only lowered when a gap follows
    // ------------------------------------------------------------------------
    task automatic issue(input logic kind, input int site, input logic spin_value,
                         input int rnd);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        start          <= 1'b1;
        i_kind         <= kind;
        i_site         <= SITE_W'(site);
        i_spin_value   <= spin_value;
        i_random_value <= RAND_W'(rnd);
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // request taken at this edge
        lattice.apply_request(kind, SITE_W'(site), spin_value, RAND_W'(rnd));
        requests_sent++;
    endtask

    // drain: no request in flight and every owed result seen
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (lattice.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both thresholds, back to back; only called while the block is idle
    task automatic program_thresholds(input logic [CFG_DW-1:0] four,
                                      input logic [CFG_DW-1:0] eight);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_THR_FOUR;
        i_cfg_data <= four;
        @(posedge i_clk);
        lattice.set_threshold(CFG_THR_FOUR, four);
        i_cfg_addr <= CFG_THR_EIGHT;
        i_cfg_data <= eight;
        @(posedge i_clk);
        lattice.set_threshold(CFG_THR_EIGHT, eight);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------------
    // load a chosen number of up neighbours around a site, then update it,
    // so every energy change from -8 to 8 gets reached
    task automatic neighbourhood_trial();
        int row;
        int col;
        int centre;
        int ups;
        int turn;
        row = int'($urandom_range(0, LATTICE_SIDE - 1));
        col = int'($urandom_range(0, LATTICE_SIDE - 1));
        // favor the borders so wrap-around gets exercised
        if ($urandom_range(0, 3) == 0)
            row = ($urandom_range(0, 1) != 0) ? 0 : LATTICE_SIDE - 1;
        if ($urandom_range(0, 3) == 0)
            col = ($urandom_range(0, 1) != 0) ? 0 : LATTICE_SIDE - 1;
        centre     = row * LATTICE_SIDE + col;
        focus_site = centre;
        ups  = int'($urandom_range(0, 4));
        turn = int'($urandom_range(0, 3));
        // now and then a neighbour keeps whatever it held
        for (int d = 0; d < 4; d++)
            if ($urandom_range(0, 7) != 0)
                issue(KIND_LOAD, lattice.neighbour_of(centre, d),
                      ((d + turn) % 4) < ups, random_draw());
        if ($urandom_range(0, 7) != 0)
            issue(KIND_LOAD, centre, 1'($urandom_range(0, 1)), random_draw());
        issue(KIND_UPDATE, centre, 1'($urandom_range(0, 1)), random_draw());
        if ($urandom_range(0, 1) != 0)
            issue(KIND_UPDATE, centre, 1'($urandom_range(0, 1)), random_draw());
    endtask

    // single request of any kind, mostly near the last trial
    task automatic stray_request();
        int site;
        if ($urandom_range(0, 9) < 7) begin
            site = focus_site;
            repeat ($urandom_range(0, 2))
                site = lattice.neighbour_of(site, int'($urandom_range(0, 3)));
        end else begin
            site = int'($urandom_range(0, (1 << SITE_W) - 1));
        end
        issue(1'($urandom_range(0, 1)), site, 1'($urandom_range(0, 1)), random_draw());
    endtask

    // blocks of random traffic, fresh thresholds at each idle boundary
    task automatic random_phase();
        int target;
        for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
            settle();
            program_thresholds(pick_threshold(), pick_threshold());
            target = requests_sent + REQUESTS_PER_BLOCK;
            while (requests_sent < target) begin
                if ($urandom_range(0, 1) != 0)
                    neighbourhood_trial();
                else
                    stray_request();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        lattice = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // wait out the clearing sweep of the lattice
        do @(posedge i_clk); while (busy !== 1'b0);

        sender_idle_pct = 10;

        // both thresholds zero: only non-positive energy changes flip
        program_thresholds(CFG_DW'(0), CFG_DW'(0));
        issue(KIND_UPDATE, 100, 1'b0, 0);                   // all up, change 8, rejected
        issue(KIND_LOAD, 0, 1'b1, (1 << RAND_W) - 1);       // load of the value already held
        issue(KIND_LOAD, 0, 1'b0, 0);                       // load down
        issue(KIND_UPDATE, 0, 1'b1, 9999);                  // down among ups, flips back
        issue(KIND_LOAD, LATTICE_SIDE - 1, 1'b0, 0);        // top right corner
        issue(KIND_LOAD, CELL_COUNT - LATTICE_SIDE, 1'b0, 0); // bottom left corner
        issue(KIND_UPDATE, CELL_COUNT - 1, 1'b0, (1 << RAND_W) - 1); // wrapped, change 0
        issue(KIND_UPDATE, CELL_COUNT - 1, 1'b1, 5000);     // change 0 again, flips up
        issue(KIND_LOAD, 2001, 1'b0, 0);                    // one down neighbour for 2000
        issue(KIND_UPDATE, 2000, 1'b0, 0);                  // change 4, threshold zero

        // thresholds at the top of the range
        settle();
        program_thresholds(CFG_DW'(10000), CFG_DW'(10000));
        issue(KIND_UPDATE, 2000, 1'b0, 9999);               // change 4 accepted
        issue(KIND_UPDATE, 2000, 1'b1, 0);                  // change -4 flips back
        issue(KIND_UPDATE, 2000, 1'b0, 10000);              // random value out of range
        issue(KIND_UPDATE, 3000, 1'b1, 9999);               // change 8 accepted
        issue(KIND_UPDATE, 3000, 1'b0, (1 << RAND_W) - 1);  // change -8
        issue(KIND_UPDATE, 3001, 1'b1, 10000);              // change 8, out of range rejected

        // thresholds above range, compared as given
        settle();
        program_thresholds(CFG_DW'((1 << CFG_DW) - 1), CFG_DW'((1 << CFG_DW) - 1));
        issue(KIND_UPDATE, 3001, 1'b0, (1 << RAND_W) - 2);  // change 8 accepted
        issue(KIND_UPDATE, 3002, 1'b1, (1 << RAND_W) - 1);  // change 4, all-ones rejected
        issue(KIND_UPDATE, 2000, 1'b0, (1 << RAND_W) - 2);  // change 4 accepted

        // split thresholds: four always, eight never
        settle();
        program_thresholds(CFG_DW'(10000), CFG_DW'(0));
        issue(KIND_UPDATE, 500, 1'b1, 0);                   // change 8 rejected
        issue(KIND_LOAD, 501, 1'b0, 0);
        issue(KIND_UPDATE, 500, 1'b0, 9999);                // change 4 accepted

        // random traffic under the three sender profiles
        sender_idle_pct = 10;
        random_phase();
        sender_idle_pct = 63;
        random_phase();
        sender_idle_pct = 0;
        random_phase();

        settle();
        if (lattice.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
src/isg_pkg.sv
src/isg_ram.sv
src/isg_site_map.sv
src/ising_metropolis_spin_update.sv
test/tb_ising_metropolis_spin_update.sv
